[sv/tt2cs_pkg.sv]
// ----------------------------------------------------------------------------
// tt2cs_pkg
// shared types, constants and character helpers for the time text parser
// ----------------------------------------------------------------------------
package tt2cs_pkg;

   // parse phases, one-hot
   typedef enum logic [8:0] {
      PH_MIN_SPACE = 9'b000000001,
      PH_MIN_SIGN  = 9'b000000010,
      PH_MIN_DIGIT = 9'b000000100,
      PH_SEC_SPACE = 9'b000001000,
      PH_SEC_SIGN  = 9'b000010000,
      PH_SEC_DIGIT = 9'b000100000,
      PH_FRACTION  = 9'b001000000,
      PH_DONE      = 9'b010000000,
      PH_FAIL      = 9'b100000000
   } phase_type;

   localparam int unsigned CENTI_W = 23;
   localparam int unsigned MIN_W   = 10;
   localparam int unsigned SEC_W   = 7;
   localparam int unsigned FRAC_W  = 7;

   // accumulators saturate one past the legal limit
   localparam logic [MIN_W-1:0] MIN_LIMIT = 10'd999;
   localparam logic [MIN_W-1:0] MIN_CAP   = 10'd1000;
   localparam logic [SEC_W-1:0] SEC_LIMIT = 7'd59;
   localparam logic [SEC_W-1:0] SEC_CAP   = 7'd60;
   localparam logic [1:0]       FRAC_MAX_DIGITS = 2'd2;

   localparam logic [12:0] CS_PER_MIN = 13'd6000;
   localparam logic [6:0]  CS_PER_SEC = 7'd100;

   // character codes
   localparam logic [7:0] CH_NUL   = 8'd0;
   localparam logic [7:0] CH_PLUS  = 8'd43;
   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_DOT   = 8'd46;
   localparam logic [7:0] CH_COLON = 8'd58;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_CR    = 8'd13;

   typedef struct packed {
      logic                valid_res;
      logic [CENTI_W-1:0]  centiseconds;
   } result_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_sign(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS);
   endfunction

   function automatic logic [3:0] digit_of(input logic [7:0] c);
      logic [7:0] d;
      d = c - CH_ZERO;
      return d[3:0];
   endfunction

   function automatic logic [MIN_W-1:0] min_acc(input logic [MIN_W-1:0] acc,
                                                input logic [3:0] d);
      logic [13:0] v;
      v = 14'(acc) * 14'd10 + 14'(d);
      return (v > 14'(MIN_CAP)) ? MIN_CAP : v[MIN_W-1:0];
   endfunction

   function automatic logic [SEC_W-1:0] sec_acc(input logic [SEC_W-1:0] acc,
                                                input logic [3:0] d);
      logic [9:0] v;
      v = 10'(acc) * 10'd10 + 10'(d);
      return (v > 10'(SEC_CAP)) ? SEC_CAP : v[SEC_W-1:0];
   endfunction

endpackage

[sv/tt2cs_parser.sv]
// ----------------------------------------------------------------------------
// tt2cs_parser
// per-character parse state and the end-of-string result
// ----------------------------------------------------------------------------
module tt2cs_parser
   import tt2cs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,        // one character beat taken
   input  logic [7:0]  char_code,
   output result_type  result       // result for the state so far
);

   phase_type          phase_ff, phase_in;
   logic [MIN_W-1:0]   min_ff, min_in;
   logic [SEC_W-1:0]   sec_ff, sec_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [1:0]         fcnt_ff, fcnt_in;
   logic               mneg_ff, mneg_in;
   logic               sneg_ff, sneg_in;

   logic               c_space, c_sign, c_digit;
   logic [3:0]         c_val;

   assign c_space = is_space(char_code);
   assign c_sign  = is_sign(char_code);
   assign c_digit = is_digit(char_code);
   assign c_val   = digit_of(char_code);

   always_comb begin
      phase_in = phase_ff;
      min_in   = min_ff;
      sec_in   = sec_ff;
      frac_in  = frac_ff;
      fcnt_in  = fcnt_ff;
      mneg_in  = mneg_ff;
      sneg_in  = sneg_ff;
      if (step) begin
         if (char_code == CH_NUL) begin
            // string ends: back to the start for the next one
            phase_in = PH_MIN_SPACE;
            min_in   = '0;
            sec_in   = '0;
            frac_in  = '0;
            fcnt_in  = '0;
            mneg_in  = 1'b0;
            sneg_in  = 1'b0;
         end else begin
            unique case (phase_ff)
               PH_MIN_SPACE, PH_MIN_SIGN: begin
                  if (phase_ff == PH_MIN_SPACE && c_space) begin
                     phase_in = PH_MIN_SPACE;
                  end else if (phase_ff == PH_MIN_SPACE && c_sign) begin
                     mneg_in  = (char_code == CH_MINUS);
                     phase_in = PH_MIN_SIGN;
                  end else if (c_digit) begin
                     min_in   = min_acc(min_ff, c_val);
                     phase_in = PH_MIN_DIGIT;
                  end else begin
                     phase_in = PH_FAIL;
                  end
               end
               PH_MIN_DIGIT: begin
                  if (c_digit) begin
                     min_in = min_acc(min_ff, c_val);
                  end else if (char_code == CH_COLON) begin
                     phase_in = PH_SEC_SPACE;
                  end else begin
                     phase_in = PH_FAIL;
                  end
               end
               PH_SEC_SPACE, PH_SEC_SIGN: begin
                  if (phase_ff == PH_SEC_SPACE && c_space) begin
                     phase_in = PH_SEC_SPACE;
                  end else if (phase_ff == PH_SEC_SPACE && c_sign) begin
                     sneg_in  = (char_code == CH_MINUS);
                     phase_in = PH_SEC_SIGN;
                  end else if (c_digit) begin
                     sec_in   = sec_acc(sec_ff, c_val);
                     phase_in = PH_SEC_DIGIT;
                  end else begin
                     phase_in = PH_FAIL;
                  end
               end
               PH_SEC_DIGIT: begin
                  if (c_digit) begin
                     sec_in = sec_acc(sec_ff, c_val);
                  end else if (char_code == CH_DOT) begin
                     phase_in = PH_FRACTION;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               PH_FRACTION: begin
                  if (c_digit && fcnt_ff < FRAC_MAX_DIGITS) begin
                     // at most one earlier digit, so the value stays below 100
                     frac_in = 7'(frac_ff * 7'd10 + 7'(c_val));
                     fcnt_in = fcnt_ff + 2'd1;
                     if (fcnt_in >= FRAC_MAX_DIGITS) begin
                        phase_in = PH_DONE;
                     end
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               PH_DONE, PH_FAIL: begin
                  phase_in = phase_ff;
               end
               default: begin
                  phase_in = PH_FAIL;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MIN_SPACE;
         min_ff   <= '0;
         sec_ff   <= '0;
         frac_ff  <= '0;
         fcnt_ff  <= '0;
         mneg_ff  <= 1'b0;
         sneg_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         min_ff   <= min_in;
         sec_ff   <= sec_in;
         frac_ff  <= frac_in;
         fcnt_ff  <= fcnt_in;
         mneg_ff  <= mneg_in;
         sneg_ff  <= sneg_in;
      end
   end

   // end-of-string evaluation
   logic               ok;
   logic [FRAC_W-1:0]  frac_cs;
   logic [CENTI_W-1:0] total;

   always_comb begin
      frac_cs = (fcnt_ff == 2'd1) ? 7'(frac_ff * 7'd10) : frac_ff;
      ok = (phase_ff == PH_SEC_DIGIT) || (phase_ff == PH_FRACTION) ||
           (phase_ff == PH_DONE);
      if (mneg_ff && min_ff != '0) ok = 1'b0;
      if (sneg_ff && sec_ff != '0) ok = 1'b0;
      if (min_ff > MIN_LIMIT || sec_ff > SEC_LIMIT) ok = 1'b0;
      total = 23'(23'(min_ff) * 23'(CS_PER_MIN)) +
              23'(14'(sec_ff) * 14'(CS_PER_SEC)) +
              23'(frac_cs);
      result.valid_res    = ok;
      result.centiseconds = ok ? total : '0;
   end

endmodule

[sv/time_text_to_centiseconds.sv]
// ----------------------------------------------------------------------------
// time_text_to_centiseconds
// parses minutes:seconds[.hh] text, one character per beat, into centiseconds
//
// throughput: one character beat per cycle while the result register can
//   move; the parse state is updated once for each character taken
// result: the result beat is shown on rsp in the cycle after the
//   terminating zero character is taken
// reset: synchronous, clears the parse state to the start of the minutes
//   field and empties the result register
// ----------------------------------------------------------------------------
module time_text_to_centiseconds
   import tt2cs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // character stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [22:0] centiseconds, [23] zero
   output logic        rsp_tuser    // [0] valid_res
);

   logic        take;      // character beat accepted this cycle
   logic        finish;    // that beat is the terminating zero
   result_type  result;

   logic        out_vld_ff, out_vld_in;
   result_type  out_res_ff, out_res_in;

   // the result register frees up in the same cycle its beat is taken, so a
   // character can enter every cycle while the consumer keeps up
   assign req_tready = !out_vld_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;
   assign finish     = take && (req_tdata == CH_NUL);

   tt2cs_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (take),
      .char_code (req_tdata),
      .result    (result)
   );

   // result register: loaded on the terminating zero, held until taken
   always_comb begin
      out_vld_in = out_vld_ff;
      out_res_in = out_res_ff;
      if (out_vld_ff && rsp_tready) begin
         out_vld_in = 1'b0;
      end
      if (finish) begin
         out_vld_in = 1'b1;
         out_res_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_res_ff <= out_res_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {1'b0, out_res_ff.centiseconds};
   assign rsp_tuser  = out_res_ff.valid_res;

   // an invalid time always reports zero centiseconds
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 24'd0)
      else $error("invalid result with nonzero centiseconds");

   // a legal time never exceeds 999:59.99
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata <= 24'd5999999)
      else $error("centiseconds out of range");

   // terminating zero yields a result beat next cycle
   a_finish_result: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_tvalid)
      else $error("missing result after end of string");

   // a character is only taken when the result register can move
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      take && out_vld_ff |-> rsp_tready)
      else $error("character taken while result stalled");

endmodule

[verif/time_text_to_centiseconds_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_text_to_centiseconds_tb
// self-checking bench for the minutes:seconds[.hh] text parser
//
// a queue of character beats is built up front: a directed set of short time
// strings covering field extremes, signs, white space, saturation and the
// malformed cases, then random strings, mostly well formed with random
// content and the rest corrupted or pure noise. the driver streams them in
// bursts with random gaps; every accepted character runs through a local
// parser model, and each terminating zero pushes one expected result. the
// monitor checks every result beat field by field against the oldest one.
// the receiver stalls on a pattern of its own and once holds off for a long
// stretch so the block backs up and stalls the character stream.
// ----------------------------------------------------------------------------
module time_text_to_centiseconds_tb
   import tt2cs_pkg::*;
();

   localparam int unsigned RESET_CYCLES = 8;
   localparam int unsigned TOTAL_CHARS  = 1850;
   localparam int unsigned HOLD_CYCLES  = 400;  // long receiver hold-off
   localparam int unsigned HOLD_AFTER   = 30;   // results taken before it
   localparam int unsigned IDLE_LIMIT   = 4000; // cycles with no beat at all
   localparam int unsigned DRAIN_CYCLES = 8;

   // receiver stall patterns
   typedef enum int unsigned {
      READY_ALWAYS,
      READY_HALF,
      READY_SPARSE
   } ready_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] char_code
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [22:0] centiseconds, [23] zero
   logic        rsp_tuser;         // [0] valid_res

   // character beats still to send, and the string under construction
   logic [7:0]  char_queue[$];
   logic [7:0]  text_buf[$];
   int unsigned chars_queued = 0;

   // parser model state
   phase_type          p_phase;
   logic [MIN_W-1:0]   p_minutes;
   logic [SEC_W-1:0]   p_seconds;
   logic [FRAC_W-1:0]  p_hundredths;
   logic [1:0]         p_frac_count;
   logic               p_min_neg;
   logic               p_sec_neg;

   result_type  expected_results[$];
   result_type  next_result;

   int unsigned mismatch_count = 0;
   int unsigned results_taken  = 0;
   int unsigned idle_cycles    = 0;

   int unsigned    burst_left;
   int unsigned    gap_left;
   int unsigned    hold_left;
   logic           hold_done;
   int unsigned    mode_left;
   ready_mode_type ready_mode;

   time_text_to_centiseconds uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // parser model
   // ---------------------------------------------------------------------

   function automatic logic char_is_blank(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic char_is_numeral(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   // decimal shift-in, clamped one past the legal limit
   function automatic int unsigned shift_in_digit(input int unsigned acc,
                                                  input logic [7:0] c,
                                                  input int unsigned cap);
      int unsigned v;
      v = acc * 10 + 32'(c - CH_ZERO);
      return (v > cap) ? cap : v;
   endfunction

   task automatic restart_parser();
      p_phase      = PH_MIN_SPACE;
      p_minutes    = '0;
      p_seconds    = '0;
      p_hundredths = '0;
      p_frac_count = '0;
      p_min_neg    = 1'b0;
      p_sec_neg    = 1'b0;
   endtask

   // one accepted character; a zero closes the string and yields a result
   task automatic advance_parser(input logic [7:0] c);
      logic        ok;
      int unsigned frac;
      result_type  res;
      if (c == CH_NUL) begin
         ok = (p_phase == PH_SEC_DIGIT) || (p_phase == PH_FRACTION) ||
              (p_phase == PH_DONE);
         // a lone fraction digit counts as tenths
         frac = (p_frac_count == 2'd1) ? 32'(p_hundredths) * 10 : 32'(p_hundredths);
         if (p_min_neg && p_minutes != 0) ok = 1'b0;
         if (p_sec_neg && p_seconds != 0) ok = 1'b0;
         if (p_minutes > MIN_LIMIT || p_seconds > SEC_LIMIT) ok = 1'b0;
         res.valid_res    = ok;
         res.centiseconds = ok ? CENTI_W'(32'(p_minutes) * 32'(CS_PER_MIN) +
                                          32'(p_seconds) * 32'(CS_PER_SEC) + frac)
                               : '0;
         expected_results.push_back(res);
         restart_parser();
      end else begin
         case (p_phase)
            PH_MIN_SPACE, PH_MIN_SIGN: begin
               if (p_phase == PH_MIN_SPACE && char_is_blank(c)) begin
                  // skip leading white space
               end else if (p_phase == PH_MIN_SPACE && (c == CH_PLUS || c == CH_MINUS)) begin
                  p_min_neg = (c == CH_MINUS);
                  p_phase   = PH_MIN_SIGN;
               end else if (char_is_numeral(c)) begin
                  p_minutes = MIN_W'(shift_in_digit(p_minutes, c, MIN_CAP));
                  p_phase   = PH_MIN_DIGIT;
               end else begin
                  p_phase = PH_FAIL;
               end
            end
            PH_MIN_DIGIT: begin
               if (char_is_numeral(c))
                  p_minutes = MIN_W'(shift_in_digit(p_minutes, c, MIN_CAP));
               else if (c == CH_COLON)
                  p_phase = PH_SEC_SPACE;
               else
                  p_phase = PH_FAIL;
            end
            PH_SEC_SPACE, PH_SEC_SIGN: begin
               if (p_phase == PH_SEC_SPACE && char_is_blank(c)) begin
                  // skip leading white space
               end else if (p_phase == PH_SEC_SPACE && (c == CH_PLUS || c == CH_MINUS)) begin
                  p_sec_neg = (c == CH_MINUS);
                  p_phase   = PH_SEC_SIGN;
               end else if (char_is_numeral(c)) begin
                  p_seconds = SEC_W'(shift_in_digit(p_seconds, c, SEC_CAP));
                  p_phase   = PH_SEC_DIGIT;
               end else begin
                  p_phase = PH_FAIL;
               end
            end
            PH_SEC_DIGIT: begin
               if (char_is_numeral(c))
                  p_seconds = SEC_W'(shift_in_digit(p_seconds, c, SEC_CAP));
               else if (c == CH_DOT)
                  p_phase = PH_FRACTION;
               else
                  p_phase = PH_DONE;
            end
            PH_FRACTION: begin
               if (char_is_numeral(c) && p_frac_count < FRAC_MAX_DIGITS) begin
                  p_hundredths = FRAC_W'(32'(p_hundredths) * 10 + 32'(c - CH_ZERO));
                  p_frac_count = p_frac_count + 2'd1;
                  if (p_frac_count >= FRAC_MAX_DIGITS) p_phase = PH_DONE;
               end else begin
                  p_phase = PH_DONE;
               end
            end
            default: begin
               // done swallows the tail, anything else sticks in fail
               if (p_phase != PH_DONE) p_phase = PH_FAIL;
            end
         endcase
      end
   endtask

   // ---------------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------------

   task automatic put_char(input logic [7:0] c);
      text_buf.push_back(c);
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endtask

   // decimal value with some leading zeros
   task automatic put_number(input int unsigned value, input int unsigned zeros);
      string s;
      s = $sformatf("%0d", value);
      repeat (zeros) text_buf.push_back(CH_ZERO);
      put_text(s);
   endtask

   task automatic put_blanks();
      repeat ($urandom_range(0, 2)) begin
         if ($urandom_range(0, 1) == 0) text_buf.push_back(CH_SPACE);
         else text_buf.push_back(8'(CH_TAB + $urandom_range(0, 4)));
      end
   endtask

   task automatic put_sign();
      case ($urandom_range(0, 7))
         0: text_buf.push_back(CH_PLUS);
         1: text_buf.push_back(CH_MINUS);
         default: ;
      endcase
   endtask

   // move the string to the send queue, optionally with one byte clobbered,
   // and close it with the terminating zero
   task automatic commit_text(input logic corrupt);
      if (corrupt && text_buf.size() != 0)
         text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(1, 255));
      foreach (text_buf[i]) char_queue.push_back(text_buf[i]);
      char_queue.push_back(CH_NUL);
      chars_queued += text_buf.size() + 1;
      text_buf.delete();
   endtask

   // ---------------------------------------------------------------------
   // driver: bursts of character beats with random gaps
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= $urandom_range(1, 12);
         gap_left   <= 0;
         restart_parser();
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            advance_parser(req_tdata);
            void'(char_queue.pop_front());
         end
         if (gap_left != 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (char_queue.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= char_queue[0];
            if (burst_left <= 1) begin
               // now and then a long burst with no idling at all
               burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                          : $urandom_range(1, 12);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // receiver: stall pattern plus one long hold-off
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
         hold_done  <= 1'b0;
         mode_left  <= 0;
         ready_mode <= READY_ALWAYS;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && results_taken >= HOLD_AFTER) begin
         // the sender keeps going, so the block backs up and stalls req
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode <= ready_mode_type'($urandom_range(0, 2));
            mode_left  <= $urandom_range(16, 96);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (ready_mode)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_HALF:   rsp_tready <= ($urandom_range(0, 1) == 0);
            default:      rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // monitor and checks
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what, input longint got,
                                  input longint want);
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_taken <= results_taken + 1;
         if (expected_results.size() == 0) begin
            report_mismatch("result beat with none expected", rsp_tdata, 0);
         end else begin
            next_result = expected_results.pop_front();
            if (rsp_tuser !== next_result.valid_res)
               report_mismatch("valid_res", rsp_tuser, next_result.valid_res);
            if (rsp_tdata[CENTI_W-1:0] !== next_result.centiseconds)
               report_mismatch("centiseconds", rsp_tdata[CENTI_W-1:0],
                               next_result.centiseconds);
            if (rsp_tdata[23] !== 1'b0)
               report_mismatch("tdata pad bit", rsp_tdata[23], 0);
         end
      end
   end

   // cycles in which neither side moves a beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // ---------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int unsigned mins;
      int unsigned secs;
      logic        timed_out;

      // directed strings
      commit_text(1'b0);                      // empty string
      put_text("0:23.26");      commit_text(1'b0);
      put_text("999:59.99");    commit_text(1'b0);  // largest legal time
      put_text("1000:0");       commit_text(1'b0);  // minutes over limit
      for (int c = CH_TAB; c <= CH_CR; c++) put_char(8'(c));
      put_char(CH_SPACE);
      put_text("+5: -0.5");     commit_text(1'b0);  // all blanks, signs, tenths
      put_text("-0:-00");       commit_text(1'b0);  // negative zero is legal
      put_text("-1:00");        commit_text(1'b0);
      put_text("1:-5");         commit_text(1'b0);
      put_text("12");           commit_text(1'b0);  // no colon
      put_text("12 :30");       commit_text(1'b0);  // minutes then non-colon
      put_text("+:30");         commit_text(1'b0);  // sign without digits
      put_text("- 1:00");       commit_text(1'b0);
      put_text(":30");          commit_text(1'b0);
      put_text("1:");           commit_text(1'b0);  // seconds missing
      put_text("1:60");         commit_text(1'b0);  // seconds over limit
      put_text("1:0123456789"); commit_text(1'b0);  // seconds saturate
      put_text("0000000007:05"); commit_text(1'b0);
      put_text("99999999:1");   commit_text(1'b0);  // minutes saturate
      put_text("1:05.1239x");   commit_text(1'b0);  // third fraction digit dropped
      put_text("1:05x9");       commit_text(1'b0);  // trailing text ignored
      put_text("1:05.");        commit_text(1'b0);
      put_text("2:3.+5");       commit_text(1'b0);
      put_text("3:4");
      put_char(8'hFF);
      put_char(8'h80);          commit_text(1'b0);
      put_char(8'hFF);
      put_text("1:00");         commit_text(1'b0);  // junk first, then ignored

      // random strings: mostly well formed, some corrupted, some noise
      while (chars_queued < TOTAL_CHARS) begin
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(0, 8)) put_char(8'($urandom_range(1, 255)));
            commit_text(1'b0);
         end else begin
            case ($urandom_range(0, 9))
               0:       mins = $urandom_range(1000, 99999);
               1:       mins = 0;
               default: mins = $urandom_range(0, 999);
            endcase
            secs = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 9999)
                                               : $urandom_range(0, 59);
            put_blanks();
            put_sign();
            put_number(mins, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
            put_char(CH_COLON);
            put_blanks();
            put_sign();
            put_number(secs, ($urandom_range(0, 3) == 0) ? 1 : 0);
            if ($urandom_range(0, 3) != 0) begin
               put_char(CH_DOT);
               repeat ($urandom_range(0, 4)) put_char(8'(CH_ZERO + $urandom_range(0, 9)));
            end
            if ($urandom_range(0, 4) == 0)
               repeat ($urandom_range(1, 4)) put_char(8'($urandom_range(1, 255)));
            commit_text($urandom_range(0, 5) == 0);
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // run until everything is sent and answered, or nothing moves for long
      while ((char_queue.size() != 0 || expected_results.size() != 0) &&
             idle_cycles < IDLE_LIMIT)
         @(posedge clock);
      timed_out = (idle_cycles >= IDLE_LIMIT);
      if (!timed_out) repeat (DRAIN_CYCLES) @(posedge clock);

      if (!timed_out && mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
